FILE: sv/jmi_pkg.sv
package jmi_pkg;

	localparam int JOINTS = 5;
	localparam int STEPS_MAX = 64;
	localparam int FRAC_BITS = 16;

	localparam int ANGLE_W = 9;
	localparam int STEP_W = 7;
	localparam int SETUP_W = 27;
	localparam int SERVO_W = 8;
	localparam int IDX_W = 3;
	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam int DIFF_W = ANGLE_W + 1;
	localparam int DIV_W = ANGLE_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int INC_W = DIV_W + 1;
	localparam int ACC_W = INC_W + 1;
	localparam int POS_W = ACC_W - FRAC_BITS;

	localparam int LO_LSB = 0;
	localparam int HI_LSB = ANGLE_W;
	localparam int OFF_LSB = 2 * ANGLE_W;

	localparam int SERVO_MAX = 180;
	localparam int SERVO_BIAS = 135;
	localparam int RECIP_3 = 683;
	localparam int RECIP_SH = 11;
	localparam int PROD_W = POS_W + 10;

	typedef logic [SETUP_W-1:0] setup_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [SERVO_W-1:0] servo_t;

	localparam setup_t SETUP_RESET [JOINTS] = '{
		setup_t'(131647920), setup_t'(3983772), setup_t'(6601124),
		setup_t'(46502), setup_t'(131688780)
	};

	localparam angle_t POSE_RESET [JOINTS] = '{
		-angle_t'(50), angle_t'(0), angle_t'(0), angle_t'(0), angle_t'(0)
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_ACC_INIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_load;
		logic div_step;
		logic div_store;
		logic acc_init;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_joint;
		logic last_step;
		logic slot_free;
	} dp_status_t;

endpackage

FILE: sv/jmi_cmd_if.sv
interface jmi_cmd_if;
	logic valid;
	logic ready;
	jmi_pkg::angle_t target_0;
	jmi_pkg::angle_t target_1;
	jmi_pkg::angle_t target_2;
	jmi_pkg::angle_t target_3;
	jmi_pkg::angle_t target_4;
	jmi_pkg::step_t step_count;

	modport source(output valid, target_0, target_1, target_2, target_3, target_4,
		step_count, input ready);
	modport sink(input valid, target_0, target_1, target_2, target_3, target_4,
		step_count, output ready);
endinterface

FILE: sv/jmi_res_if.sv
interface jmi_res_if;
	logic valid;
	logic ready;
	jmi_pkg::servo_t servo_0;
	jmi_pkg::servo_t servo_1;
	jmi_pkg::servo_t servo_2;
	jmi_pkg::servo_t servo_3;
	jmi_pkg::servo_t servo_4;
	jmi_pkg::step_t step_number;
	logic last_step;
	logic limit_clamped;

	modport source(output valid, servo_0, servo_1, servo_2, servo_3, servo_4,
		step_number, last_step, limit_clamped, input ready);
	modport sink(input valid, servo_0, servo_1, servo_2, servo_3, servo_4,
		step_number, last_step, limit_clamped, output ready);
endinterface

FILE: sv/jmi_ctrl.sv
module jmi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  jmi_pkg::dp_status_t    status,
	output jmi_pkg::ctrl_cmd_t     ctrl
);

	jmi_pkg::state_t state_q;
	jmi_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jmi_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			jmi_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_next = jmi_pkg::ST_DIV_LOAD;
				end
			end
			jmi_pkg::ST_DIV_LOAD: begin
				state_next = jmi_pkg::ST_DIV_RUN;
			end
			jmi_pkg::ST_DIV_RUN: begin
				if (status.div_done) begin
					state_next = jmi_pkg::ST_DIV_STORE;
				end
			end
			jmi_pkg::ST_DIV_STORE: begin
				if (status.last_joint) begin
					state_next = jmi_pkg::ST_ACC_INIT;
				end else begin
					state_next = jmi_pkg::ST_DIV_LOAD;
				end
			end
			jmi_pkg::ST_ACC_INIT: begin
				state_next = jmi_pkg::ST_EMIT;
			end
			jmi_pkg::ST_EMIT: begin
				if (status.slot_free && status.last_step) begin
					state_next = jmi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = jmi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			jmi_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				ctrl.load = cmd_valid;
			end
			jmi_pkg::ST_DIV_LOAD: begin
				ctrl.div_load = 1'b1;
			end
			jmi_pkg::ST_DIV_RUN: begin
				ctrl.div_step = 1'b1;
			end
			jmi_pkg::ST_DIV_STORE: begin
				ctrl.div_store = 1'b1;
			end
			jmi_pkg::ST_ACC_INIT: begin
				ctrl.acc_init = 1'b1;
			end
			jmi_pkg::ST_EMIT: begin
				ctrl.emit = status.slot_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

FILE: sv/jmi_dp.sv
module jmi_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  jmi_pkg::ctrl_cmd_t      ctrl,
	output jmi_pkg::dp_status_t     status,
	input  logic                    cfg_we,
	input  logic [jmi_pkg::IDX_W-1:0] cfg_index,
	input  jmi_pkg::setup_t         cfg_data,
	input  jmi_pkg::angle_t         target [jmi_pkg::JOINTS],
	input  jmi_pkg::step_t          step_count,
	input  logic                    res_ready,
	output logic                    res_valid,
	output jmi_pkg::servo_t         servo [jmi_pkg::JOINTS],
	output jmi_pkg::step_t          step_number,
	output logic                    last_step,
	output logic                    limit_clamped
);

	function automatic jmi_pkg::servo_t servo_of(
		input logic signed [jmi_pkg::ACC_W-1:0] acc,
		input jmi_pkg::angle_t off
	);
		logic signed [jmi_pkg::POS_W-1:0] pos;
		logic signed [jmi_pkg::POS_W:0] v;
		logic [jmi_pkg::POS_W-1:0] x;
		logic [jmi_pkg::PROD_W-1:0] prod;
		logic [jmi_pkg::PROD_W-jmi_pkg::RECIP_SH-1:0] t;
		jmi_pkg::servo_t code;
		pos = acc[jmi_pkg::ACC_W-1:jmi_pkg::FRAC_BITS];
		// Rounding the floor up gives truncation toward zero for negative values.
		if (acc[jmi_pkg::ACC_W-1] && (acc[jmi_pkg::FRAC_BITS-1:0] != '0)) begin
			pos = pos + jmi_pkg::POS_W'(1);
		end
		v = (jmi_pkg::POS_W+1)'(pos) + (jmi_pkg::POS_W+1)'(off)
			+ (jmi_pkg::POS_W+1)'(jmi_pkg::SERVO_BIAS);
		x = {v[jmi_pkg::POS_W-2:0], 1'b0};
		prod = jmi_pkg::PROD_W'(x) * jmi_pkg::PROD_W'(jmi_pkg::RECIP_3);
		t = prod[jmi_pkg::PROD_W-1:jmi_pkg::RECIP_SH];
		if (v <= 0) begin
			code = '0;
		end else if (t > (jmi_pkg::PROD_W-jmi_pkg::RECIP_SH)'(jmi_pkg::SERVO_MAX)) begin
			code = jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX);
		end else begin
			code = t[jmi_pkg::SERVO_W-1:0];
		end
		return code;
	endfunction

	jmi_pkg::setup_t setup_q [jmi_pkg::JOINTS];
	jmi_pkg::angle_t cur_q [jmi_pkg::JOINTS];
	jmi_pkg::angle_t tgt_q [jmi_pkg::JOINTS];
	logic signed [jmi_pkg::INC_W-1:0] inc_q [jmi_pkg::JOINTS];
	logic signed [jmi_pkg::ACC_W-1:0] acc_q [jmi_pkg::JOINTS];
	jmi_pkg::step_t n_q;
	jmi_pkg::step_t step_q;
	logic clamp_q;

	logic [jmi_pkg::DIV_W-1:0] quo_q;
	jmi_pkg::step_t rem_q;
	logic neg_q;
	logic [jmi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [jmi_pkg::JIDX_W-1:0] jidx_q;

	jmi_pkg::servo_t servo_q [jmi_pkg::JOINTS];
	jmi_pkg::step_t step_out_q;
	logic last_out_q;
	logic clamp_out_q;
	logic valid_q;

	jmi_pkg::angle_t tgt_clamped [jmi_pkg::JOINTS];
	logic [jmi_pkg::JOINTS-1:0] hit;
	jmi_pkg::step_t n_sat;
	logic signed [jmi_pkg::DIFF_W-1:0] diff;
	logic [jmi_pkg::DIFF_W-1:0] mag;
	logic [jmi_pkg::STEP_W:0] trial;
	logic [jmi_pkg::STEP_W:0] trial_sub;
	logic trial_ge;
	logic slot_free;

	always_comb begin
		for (int i = 0; i < jmi_pkg::JOINTS; i++) begin
			jmi_pkg::angle_t lo;
			jmi_pkg::angle_t hi;
			lo = setup_q[i][jmi_pkg::LO_LSB +: jmi_pkg::ANGLE_W];
			hi = setup_q[i][jmi_pkg::HI_LSB +: jmi_pkg::ANGLE_W];
			hit[i] = 1'b1;
			if (target[i] > hi) begin
				tgt_clamped[i] = hi;
			end else if (target[i] < lo) begin
				tgt_clamped[i] = lo;
			end else begin
				tgt_clamped[i] = target[i];
				hit[i] = 1'b0;
			end
		end
	end

	always_comb begin
		if (step_count == '0) begin
			n_sat = jmi_pkg::STEP_W'(1);
		end else if (step_count > jmi_pkg::STEP_W'(jmi_pkg::STEPS_MAX)) begin
			n_sat = jmi_pkg::STEP_W'(jmi_pkg::STEPS_MAX);
		end else begin
			n_sat = step_count;
		end
	end

	assign diff = jmi_pkg::DIFF_W'(tgt_q[jidx_q]) - jmi_pkg::DIFF_W'(cur_q[jidx_q]);
	assign mag = diff[jmi_pkg::DIFF_W-1] ? -diff : diff;
	assign trial = {rem_q, quo_q[jmi_pkg::DIV_W-1]};
	assign trial_ge = trial >= {1'b0, n_q};
	assign trial_sub = trial - {1'b0, n_q};
	assign slot_free = !valid_q || res_ready;

	assign status.div_done = cnt_q == jmi_pkg::DIV_CNT_W'(jmi_pkg::DIV_W - 1);
	assign status.last_joint = jidx_q == jmi_pkg::JIDX_W'(jmi_pkg::JOINTS - 1);
	assign status.last_step = step_q == n_q;
	assign status.slot_free = slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= jmi_pkg::SETUP_RESET;
			cur_q <= jmi_pkg::POSE_RESET;
			valid_q <= 1'b0;
			cnt_q <= '0;
			jidx_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_we && ({1'b0, cfg_index} < (jmi_pkg::IDX_W+1)'(jmi_pkg::JOINTS))) begin
				setup_q[cfg_index[jmi_pkg::JIDX_W-1:0]] <= cfg_data;
			end
			if (ctrl.load) begin
				jidx_q <= '0;
				step_q <= jmi_pkg::STEP_W'(1);
			end
			if (ctrl.div_load) begin
				cnt_q <= '0;
			end
			if (ctrl.div_step) begin
				cnt_q <= cnt_q + jmi_pkg::DIV_CNT_W'(1);
			end
			if (ctrl.div_store) begin
				jidx_q <= jidx_q + jmi_pkg::JIDX_W'(1);
			end
			if (ctrl.emit) begin
				valid_q <= 1'b1;
				step_q <= step_q + jmi_pkg::STEP_W'(1);
				if (step_q == n_q) begin
					cur_q <= tgt_q;
				end
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			tgt_q <= tgt_clamped;
			clamp_q <= |hit;
			n_q <= n_sat;
		end
		if (ctrl.div_load) begin
			neg_q <= diff[jmi_pkg::DIFF_W-1];
			quo_q <= {mag[jmi_pkg::ANGLE_W-1:0], jmi_pkg::FRAC_BITS'(0)};
			rem_q <= '0;
		end
		if (ctrl.div_step) begin
			quo_q <= {quo_q[jmi_pkg::DIV_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[jmi_pkg::STEP_W-1:0] : trial[jmi_pkg::STEP_W-1:0];
		end
		if (ctrl.div_store) begin
			inc_q[jidx_q] <= neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		end
		for (int i = 0; i < jmi_pkg::JOINTS; i++) begin
			if (ctrl.acc_init) begin
				acc_q[i] <= (jmi_pkg::ACC_W'(cur_q[i]) <<< jmi_pkg::FRAC_BITS)
					+ jmi_pkg::ACC_W'(inc_q[i]);
			end else if (ctrl.emit) begin
				acc_q[i] <= acc_q[i] + jmi_pkg::ACC_W'(inc_q[i]);
			end
			if (ctrl.emit) begin
				servo_q[i] <= servo_of(acc_q[i], setup_q[i][jmi_pkg::OFF_LSB +: jmi_pkg::ANGLE_W]);
			end
		end
		if (ctrl.emit) begin
			step_out_q <= step_q;
			last_out_q <= step_q == n_q;
			clamp_out_q <= clamp_q;
		end
	end

	assign res_valid = valid_q;
	assign servo = servo_q;
	assign step_number = step_out_q;
	assign last_step = last_out_q;
	assign limit_clamped = clamp_out_q;

endmodule

FILE: sv/joint_move_interpolator.sv
// Linear joint move interpolator for a five-joint arm.
// A command item on cmd carries five target angles in degrees and a step
// count. Each target is clamped to its joint limits, the per-step increment
// is divided out in fixed point with 16 fraction bits, and then one result
// item per step leaves on res with the five servo codes, the step number, a
// last-step flag and a flag telling whether any target was clamped.
// Joint limits and offsets are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. An index beyond the last joint is ignored.
// The increments come from one shared restoring divider that works through
// the joints in turn before the first result is produced. After that one
// result is produced per cycle while the receiver keeps res.ready high.
// cmd.ready is high only while no command is in progress.
// When the receiver holds res.ready low, the result register keeps its item
// and the step sequence waits; nothing is dropped.
// Reset restores the default limits and offsets and the home pose of
// -50, 0, 0, 0, 0 degrees, and leaves no result pending.
module joint_move_interpolator (
	input  logic                      clk,
	input  logic                      arst_n,
	jmi_cmd_if.sink                   cmd,
	jmi_res_if.source                 res,
	input  logic                      cfg_we,
	input  logic [jmi_pkg::IDX_W-1:0] cfg_index,
	input  jmi_pkg::setup_t           cfg_data
);

	jmi_pkg::ctrl_cmd_t ctrl;
	jmi_pkg::dp_status_t status;
	jmi_pkg::angle_t target [jmi_pkg::JOINTS];
	jmi_pkg::servo_t servo [jmi_pkg::JOINTS];

	assign target[0] = cmd.target_0;
	assign target[1] = cmd.target_1;
	assign target[2] = cmd.target_2;
	assign target[3] = cmd.target_3;
	assign target[4] = cmd.target_4;

	assign res.servo_0 = servo[0];
	assign res.servo_1 = servo[1];
	assign res.servo_2 = servo[2];
	assign res.servo_3 = servo[3];
	assign res.servo_4 = servo[4];

	jmi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.status    (status),
		.ctrl      (ctrl)
	);

	jmi_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.target        (target),
		.step_count    (cmd.step_count),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.servo         (servo),
		.step_number   (res.step_number),
		.last_step     (res.last_step),
		.limit_clamped (res.limit_clamped)
	);

endmodule

FILE: sv/jmi_checker.sv
module jmi_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input jmi_pkg::servo_t      servo_0,
	input jmi_pkg::servo_t      servo_1,
	input jmi_pkg::servo_t      servo_2,
	input jmi_pkg::servo_t      servo_3,
	input jmi_pkg::servo_t      servo_4,
	input jmi_pkg::step_t       step_number,
	input logic                 last_step
);

	// Every servo code on a valid item stays within the servo range.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> servo_0 <= jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX)
			&& servo_1 <= jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX)
			&& servo_2 <= jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX)
			&& servo_3 <= jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX)
			&& servo_4 <= jmi_pkg::SERVO_W'(jmi_pkg::SERVO_MAX))
		else $error("servo code out of range");

	// Step numbers run from one up to the maximum step count.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step_number != '0
			&& step_number <= jmi_pkg::STEP_W'(jmi_pkg::STEPS_MAX))
		else $error("step number out of range");

	// A command in progress blocks the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted while busy");

	// While the command port is open, only the last step of a move can be waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ready && res_valid) |-> last_step)
		else $error("command port opened before the move finished");

	// A stalled result item stays valid and keeps its step number.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(step_number))
		else $error("stalled result item changed");

endmodule

bind joint_move_interpolator jmi_checker u_jmi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.servo_0     (res.servo_0),
	.servo_1     (res.servo_1),
	.servo_2     (res.servo_2),
	.servo_3     (res.servo_3),
	.servo_4     (res.servo_4),
	.step_number (res.step_number),
	.last_step   (res.last_step)
);

FILE: bench/joint_move_checker.sv
module joint_move_checker
	import jmi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	jmi_cmd_if               cmd,
	jmi_res_if               res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  setup_t           cfg_data,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT = longint'(1) << FRAC_BITS;
	localparam longint SERVO_SPAN = 270;

	typedef struct packed {
		servo_t [JOINTS-1:0] servo;
		step_t               step_number;
		logic                last_step;
		logic                limit_clamped;
	} servo_step_t;

	setup_t      joint_setup [JOINTS];
	longint      pose [JOINTS];
	servo_step_t expected_steps [$];

	function automatic longint setup_field(setup_t s, int lsb);
		angle_t a;
		a = s[lsb +: ANGLE_W];
		return a;
	endfunction

	function automatic void plan_move(input logic [JOINTS-1:0][ANGLE_W-1:0] tgts,
		input step_t cnt);
		longint n, lo, hi, t, off, fx, pos, code;
		longint inc [JOINTS];
		longint dest [JOINTS];
		angle_t a;
		logic clamp;
		servo_step_t r;
		int i, j;
		clamp = 1'b0;
		n = cnt;
		if (n < 1)
			n = 1;
		if (n > STEPS_MAX)
			n = STEPS_MAX;
		for (i = 0; i < JOINTS; i++) begin
			lo = setup_field(joint_setup[i], LO_LSB);
			hi = setup_field(joint_setup[i], HI_LSB);
			a = tgts[i];
			t = a;
			if (t > hi) begin
				t = hi;
				clamp = 1'b1;
			end else if (t < lo) begin
				t = lo;
				clamp = 1'b1;
			end
			dest[i] = t;
			inc[i] = ((t - pose[i]) * UNIT) / n;
		end
		for (j = 1; j <= n; j++) begin
			for (i = 0; i < JOINTS; i++) begin
				fx = pose[i] * UNIT + inc[i] * j;
				pos = fx / UNIT;
				off = setup_field(joint_setup[i], OFF_LSB);
				code = ((pos + off + SERVO_BIAS) * SERVO_MAX) / SERVO_SPAN;
				if (code > SERVO_MAX)
					code = SERVO_MAX;
				else if (code <= 0)
					code = 0;
				r.servo[i] = servo_t'(code);
			end
			r.step_number = step_t'(j);
			r.last_step = (j == n);
			r.limit_clamped = clamp;
			expected_steps.push_back(r);
		end
		for (i = 0; i < JOINTS; i++)
			pose[i] = dest[i];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		servo_step_t want;
		logic [JOINTS-1:0][SERVO_W-1:0] got;
		int bad;
		int i;
		if (!arst_n) begin
			for (i = 0; i < JOINTS; i++) begin
				joint_setup[i] = SETUP_RESET[i];
				pose[i] = POSE_RESET[i];
			end
			expected_steps.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (res.valid && res.ready) begin
				got = {res.servo_4, res.servo_3, res.servo_2, res.servo_1, res.servo_0};
				if (expected_steps.size() == 0) begin
					$error("result item with none expected: step_number %0d",
						res.step_number);
					bad++;
				end else begin
					want = expected_steps.pop_front();
					for (i = 0; i < JOINTS; i++) begin
						if (want.servo[i] != got[i]) begin
							$error("servo_%0d expected %0d actual %0d", i,
								want.servo[i], got[i]);
							bad++;
						end
					end
					if (want.step_number != res.step_number) begin
						$error("step_number expected %0d actual %0d",
							want.step_number, res.step_number);
						bad++;
					end
					if (want.last_step != res.last_step) begin
						$error("last_step expected %0d actual %0d",
							want.last_step, res.last_step);
						bad++;
					end
					if (want.limit_clamped != res.limit_clamped) begin
						$error("limit_clamped expected %0d actual %0d",
							want.limit_clamped, res.limit_clamped);
						bad++;
					end
				end
			end
			if (cfg_we && cfg_index < JOINTS)
				joint_setup[cfg_index] = cfg_data;
			if (cmd.valid && cmd.ready)
				plan_move({cmd.target_4, cmd.target_3, cmd.target_2, cmd.target_1,
					cmd.target_0}, cmd.step_count);
			errors <= errors + bad;
			pending <= expected_steps.size();
		end
	end

endmodule

FILE: bench/joint_move_interpolator_test.sv
module joint_move_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import jmi_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_MOVES = 240;
	localparam int PHASE_MOVES = 40;
	localparam int QUIET_PHASE = 3;
	localparam int IDLE_PCT = 9;
	localparam int SETTLE_CYCLES = 8;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	setup_t           cfg_data;
	logic             idle_on;
	int               errors;
	int               pending;
	int               cycles = 0;
	setup_t           setups [JOINTS];

	jmi_cmd_if cmd_ch ();
	jmi_res_if res_ch ();

	joint_move_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	joint_move_checker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("joint_move_interpolator test failed");
			$finish;
		end
	end

	function automatic setup_t pack_setup(int lo, int hi, int off);
		return {off[ANGLE_W-1:0], hi[ANGLE_W-1:0], lo[ANGLE_W-1:0]};
	endfunction

	function automatic angle_t pick_target(setup_t s);
		angle_t lo, hi;
		lo = s[LO_LSB +: ANGLE_W];
		hi = s[HI_LSB +: ANGLE_W];
		if ($urandom_range(99) < 30 || lo > hi)
			return angle_t'($urandom);
		return angle_t'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
	endfunction

	function automatic step_t pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return step_t'($urandom_range(16));
		if (r < 95)
			return step_t'($urandom_range(64, 17));
		return step_t'($urandom_range(127, 65));
	endfunction

	task automatic send_move(input angle_t t0, input angle_t t1, input angle_t t2,
		input angle_t t3, input angle_t t4, input step_t n);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.target_0 <= t0;
		cmd_ch.target_1 <= t1;
		cmd_ch.target_2 <= t2;
		cmd_ch.target_3 <= t3;
		cmd_ch.target_4 <= t4;
		cmd_ch.step_count <= n;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	task automatic send_random_move();
		send_move(pick_target(setups[0]), pick_target(setups[1]), pick_target(setups[2]),
			pick_target(setups[3]), pick_target(setups[4]), pick_count());
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !cmd_ch.ready)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_setups();
		int i;
		for (i = 0; i < JOINTS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= setups[i];
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_index <= IDX_W'(JOINTS + $urandom_range((1 << IDX_W) - 1 - JOINTS));
		cfg_data <= setup_t'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_setups();
		int i;
		for (i = 0; i < JOINTS; i++) begin
			if ($urandom_range(3) == 0)
				setups[i] = setup_t'($urandom);
			else
				setups[i] = pack_setup(-int'($urandom_range(256)), int'($urandom_range(255)),
					int'($urandom_range(511)) - 256);
		end
	endtask

	task automatic set_all_setups(setup_t s);
		int i;
		for (i = 0; i < JOINTS; i++)
			setups[i] = s;
	endtask

	initial begin
		int m;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_on <= 1'b1;
		cmd_ch.valid <= 1'b0;
		cmd_ch.target_0 <= '0;
		cmd_ch.target_1 <= '0;
		cmd_ch.target_2 <= '0;
		cmd_ch.target_3 <= '0;
		cmd_ch.target_4 <= '0;
		cmd_ch.step_count <= '0;
		setups = SETUP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_move(0, 0, 0, 0, 0, 1);
		send_move(255, 255, 255, 255, 255, 0);
		send_move(-256, -256, -256, -256, -256, 64);
		send_move(-255, -255, -255, -255, -255, 2);
		send_move(1, 1, 1, 1, 1, 3);
		send_move(-1, -2, -3, -4, -5, 7);
		send_move(37, -61, 88, -12, 140, 127);
		send_move(-20, 45, -70, 66, -150, 65);
		send_move(100, 100, 92, 90, 180, 5);
		send_move(-80, -100, -92, -90, -180, 4);
		send_move(50, -50, 17, -17, 99, 63);
		drain();

		set_all_setups(pack_setup(-256, 255, 255));
		program_setups();
		send_move(255, 255, 255, 255, 255, 2);
		send_move(-256, -256, -256, -256, -256, 1);
		send_move(0, 0, 0, 0, 0, 0);
		send_move(100, -100, 100, -100, 100, 5);
		drain();

		set_all_setups(pack_setup(-256, 255, -256));
		program_setups();
		send_move(255, 255, 255, 255, 255, 3);
		send_move(-256, 0, 255, -1, 128, 6);
		send_move(200, 180, -90, 45, 0, 64);
		drain();

		set_all_setups(pack_setup(100, -100, 0));
		program_setups();
		send_move(200, -200, 0, 255, -256, 2);
		send_move(-100, 100, -99, 99, 0, 4);
		drain();

		for (m = 0; m < RANDOM_MOVES; m++) begin
			if (m % PHASE_MOVES == 0) begin
				drain();
				random_setups();
				program_setups();
				idle_on <= (m / PHASE_MOVES != QUIET_PHASE);
			end
			send_random_move();
		end
		drain();

		if (errors == 0)
			$display("joint_move_interpolator test passed");
		else
			$display("joint_move_interpolator test failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/jmi_pkg.sv
sv/jmi_cmd_if.sv
sv/jmi_res_if.sv
sv/jmi_ctrl.sv
sv/jmi_dp.sv
sv/joint_move_interpolator.sv
sv/jmi_checker.sv
bench/joint_move_checker.sv
bench/joint_move_interpolator_test.sv
